// ===== design/sipq_pkg.sv =====
// shared types and codes for the sorted insert priority queue
// used by sipq_ctrl, sipq_datapath and the top level; depends on nothing
package sipq_pkg;

    // request codes; the unused code behaves as inspect
    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_INSPECT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // memory read address relative to the working or scan index
    typedef enum logic [2:0] {
        RD_BELOW,
        RD_BELOW2,
        RD_ABOVE,
        RD_ABOVE2,
        RD_POS,
        RD_POS1
    } rd_sel_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;          // latch request, set working index
        logic       rd_en;         // issue a memory read
        rd_sel_t    rd_sel;        // which entry to read
        logic       wr_shift;      // write last read entry at index
        logic       wr_item;       // write the new item at index
        logic       idx_inc;
        logic       idx_dec;
        logic       pos_inc;       // advance the insert point scan
        logic       occ_inc;
        logic       occ_dec;
        logic       publish;       // load the result register
        logic [1:0] result_status;
    } sipq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] action;
        logic       order_mode;
        logic       full;
        logic       empty;
        logic       occ_one;
        logic       idx_zero;
        logic       scan_last;     // scan index is at the last entry
        logic       shift_last;    // working index is just above the insert point
        logic       key_gt;        // read key above the new key
        logic       rem_more;      // another entry left to move down
        logic       out_busy;      // result register cannot take a result
    } sipq_stat_t;

endpackage

// ===== design/sipq_ctrl.sv =====
// controller state machine for the sorted insert priority queue
// depends on sipq_pkg; drives the datapath by sipq_cmd_t
module sipq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sipq_pkg::sipq_stat_t stat,
    output sipq_pkg::sipq_cmd_t  cmd
);
    import sipq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_INS_CMP,
        S_WRITE_NEW,
        S_REM_MOVE,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_BELOW;
        cmd.result_status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                state_next  = S_FINISH;
                if (stat.action == ACT_INSERT)
                begin
                    if (stat.full)
                        status_next = ST_FULL;
                    else if (!stat.order_mode || stat.idx_zero)
                        state_next = S_WRITE_NEW;
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_POS;
                        state_next = S_INS_SCAN;
                    end
                end
                else if (stat.action == ACT_REMOVE)
                begin
                    if (stat.empty)
                        status_next = ST_EMPTY;
                    else if (stat.occ_one)
                        cmd.occ_dec = 1'b1;
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_ABOVE;
                        state_next = S_REM_MOVE;
                    end
                end
            end
            S_INS_SCAN:
            begin
                // find the first entry from the head with a larger key
                if (stat.key_gt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_BELOW;
                    state_next = S_INS_CMP;
                end
                else if (stat.scan_last)
                    state_next = S_WRITE_NEW;
                else
                begin
                    cmd.pos_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_POS1;
                end
            end
            S_INS_CMP:
            begin
                // move entries from the insert point on one place toward the tail
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
                if (stat.shift_last)
                    state_next = S_WRITE_NEW;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_BELOW2;
                end
            end
            S_WRITE_NEW:
            begin
                cmd.wr_item = 1'b1;
                cmd.occ_inc = 1'b1;
                state_next  = S_FINISH;
            end
            S_REM_MOVE:
            begin
                // move each entry one place toward the head
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (stat.rem_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ABOVE2;
                end
                else
                begin
                    cmd.occ_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== design/sipq_datapath.sv =====
// datapath of the sorted insert priority queue: entry memories, counters,
// head copy, mode register and result register; depends on sipq_pkg
module sipq_datapath #(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int DATA_BITS = 32,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic [1:0]            action,
    input  logic [KEY_BITS-1:0]   item_key,
    input  logic [DATA_BITS-1:0]  item_payload,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [KEY_BITS-1:0]   head_key,
    output logic [DATA_BITS-1:0]  head_payload,
    output logic                  queue_empty,
    output logic                  queue_full,
    output logic [CNT_W-1:0]      entry_count,
    output logic [1:0]            status,
    input  sipq_pkg::sipq_cmd_t   cmd,
    output sipq_pkg::sipq_stat_t  stat
);
    import sipq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_BITS-1:0]  key_mem [DEPTH];
    logic [DATA_BITS-1:0] pay_mem [DEPTH];

    logic                 order_mode_reg;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     pos_reg;
    logic [1:0]           action_reg;
    logic [KEY_BITS-1:0]  item_key_reg;
    logic [DATA_BITS-1:0] item_pay_reg;
    logic [KEY_BITS-1:0]  rd_key_reg;
    logic [DATA_BITS-1:0] rd_pay_reg;
    logic [KEY_BITS-1:0]  head_key_reg;
    logic [DATA_BITS-1:0] head_pay_reg;

    logic                 out_valid_reg;
    logic [KEY_BITS-1:0]  out_key_reg;
    logic [DATA_BITS-1:0] out_pay_reg;
    logic                 out_empty_reg;
    logic                 out_full_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic [1:0]           out_status_reg;

    logic [CNT_W-1:0]     rd_addr_w;
    logic [CNT_W:0]       idx_plus2;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_BITS-1:0]  wr_key;
    logic [DATA_BITS-1:0] wr_pay;

    // read address around the working or scan index
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_BELOW:  rd_addr_w = idx_reg - CNT_W'(1);
            RD_BELOW2: rd_addr_w = idx_reg - CNT_W'(2);
            RD_ABOVE:  rd_addr_w = idx_reg + CNT_W'(1);
            RD_ABOVE2: rd_addr_w = idx_reg + CNT_W'(2);
            RD_POS:    rd_addr_w = pos_reg;
            RD_POS1:   rd_addr_w = pos_reg + CNT_W'(1);
            default:   rd_addr_w = idx_reg;
        endcase
    end

    // write port: shifted entry or new item
    assign wr_en   = cmd.wr_shift | cmd.wr_item;
    assign wr_addr = idx_reg[IDX_W-1:0];
    assign wr_key  = cmd.wr_item ? item_key_reg : rd_key_reg;
    assign wr_pay  = cmd.wr_item ? item_pay_reg : rd_pay_reg;

    // entry memories with registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr_w[IDX_W-1:0]];
            rd_pay_reg <= pay_mem[rd_addr_w[IDX_W-1:0]];
        end
    end

    // request latch and head copy
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_key_reg <= item_key;
            item_pay_reg <= item_payload;
        end
        if (wr_en && (idx_reg == '0))
        begin
            head_key_reg <= wr_key;
            head_pay_reg <= wr_pay;
        end
    end

    // working index and occupancy
    always_comb
    begin
        idx_next = idx_reg;
        occ_next = occ_reg;
        if (cmd.load)
            idx_next = (action == ACT_INSERT) ? occ_reg : '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CNT_W'(1);
        else if (cmd.idx_dec)
            idx_next = idx_reg - CNT_W'(1);
        if (cmd.occ_inc)
            occ_next = occ_reg + CNT_W'(1);
        else if (cmd.occ_dec)
            occ_next = occ_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= 1'b1;
            occ_reg        <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            action_reg     <= ACT_INSPECT;
        end
        else
        begin
            if (cfg_we)
                order_mode_reg <= cfg_wdata;
            occ_reg <= occ_next;
            idx_reg <= idx_next;
            if (cmd.load)
                pos_reg <= '0;
            else if (cmd.pos_inc)
                pos_reg <= pos_reg + CNT_W'(1);
            if (cmd.load)
                action_reg <= action;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_key_reg    <= (occ_reg == '0) ? '0 : head_key_reg;
            out_pay_reg    <= (occ_reg == '0) ? '0 : head_pay_reg;
            out_empty_reg  <= (occ_reg == '0);
            out_full_reg   <= (occ_reg == CNT_W'(DEPTH));
            out_count_reg  <= occ_reg;
            out_status_reg <= cmd.result_status;
        end
    end

    // status to the controller
    assign idx_plus2       = {1'b0, idx_reg} + (CNT_W + 1)'(2);
    assign stat.action     = action_reg;
    assign stat.order_mode = order_mode_reg;
    assign stat.full       = (occ_reg == CNT_W'(DEPTH));
    assign stat.empty      = (occ_reg == '0);
    assign stat.occ_one    = (occ_reg == CNT_W'(1));
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.scan_last  = ((pos_reg + CNT_W'(1)) == occ_reg);
    assign stat.shift_last = (idx_reg == (pos_reg + CNT_W'(1)));
    assign stat.key_gt     = (rd_key_reg > item_key_reg);
    assign stat.rem_more   = (idx_plus2 < {1'b0, occ_reg});
    assign stat.out_busy   = out_valid_reg & ~out_ready;

    assign out_valid    = out_valid_reg;
    assign head_key     = out_key_reg;
    assign head_payload = out_pay_reg;
    assign queue_empty  = out_empty_reg;
    assign queue_full   = out_full_reg;
    assign entry_count  = out_count_reg;
    assign status       = out_status_reg;

endmodule

// ===== design/sorted_insert_priority_queue.sv =====
// top level of the sorted insert priority queue
// depends on sipq_pkg, sipq_ctrl and sipq_datapath
//
// usage:
//   requests enter on in_valid/in_ready with action, item_key and item_payload;
//   action insert places the item before the first entry with a larger key
//   (or at the tail when order_mode is 0), remove drops the head, inspect and
//   the unused code only report. every request gives one result item on
//   out_valid/out_ready: head after the request, empty, full, count, status.
//   order_mode is written by cfg_we/cfg_wdata; the user must write it only
//   while no request is in flight; the block itself does not enforce this.
// sequence, one request at a time: an ordered insert scans from the head and,
//   unless the item goes to the tail, then shifts from the tail. in_ready rises
//   with out_valid.
// reset: rst_n clears the queue to empty, order_mode to 1 and drops out_valid.
// stalls: the result waits in its register; the next request is accepted
//   meanwhile and holds in its last step until the slot frees.
module sorted_insert_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [KEY_BITS-1:0]          item_key,
    input  logic [DATA_BITS-1:0]         item_payload,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [KEY_BITS-1:0]          head_key,
    output logic [DATA_BITS-1:0]         head_payload,
    output logic                         queue_empty,
    output logic                         queue_full,
    output logic [$clog2(DEPTH+1)-1:0]   entry_count,
    output logic [1:0]                   status
);
    import sipq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    sipq_cmd_t  cmd;
    sipq_stat_t stat;

    // request sequencing
    sipq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry storage and result register
    sipq_datapath #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS),
        .CNT_W     (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .action       (action),
        .item_key     (item_key),
        .item_payload (item_payload),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .head_key     (head_key),
        .head_payload (head_payload),
        .queue_empty  (queue_empty),
        .queue_full   (queue_full),
        .entry_count  (entry_count),
        .status       (status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== tb/sv/sipq_checker.sv =====
// result checker for the sorted insert priority queue: follows the request,
// result and config ports, predicts every result and compares it field by field
// depends on sipq_pkg for the request and status codes
module sipq_checker #(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [KEY_BITS-1:0]          item_key,
    input  logic [DATA_BITS-1:0]         item_payload,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [KEY_BITS-1:0]          head_key,
    input  logic [DATA_BITS-1:0]         head_payload,
    input  logic                         queue_empty,
    input  logic                         queue_full,
    input  logic [$clog2(DEPTH+1)-1:0]   entry_count,
    input  logic [1:0]                   status,
    output int                           fail_count,
    output int                           waiting_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sipq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // one result item as the block reports it
    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] payload;
        logic                 empty;
        logic                 full;
        logic [CNT_W-1:0]     count;
        logic [1:0]           status;
    } head_report_t;

    // shadow copy of the queue, entries 0..occupancy-1 in service order
    logic [KEY_BITS-1:0]  shadow_keys [DEPTH];
    logic [DATA_BITS-1:0] shadow_payloads [DEPTH];
    int                   occupancy;
    logic                 by_key;

    head_report_t expected_heads[$];
    head_report_t seen;
    head_report_t want;

    // apply one request to the shadow queue and return the report it gives
    function automatic head_report_t apply_request(input logic [1:0] act,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [DATA_BITS-1:0] pay);
        head_report_t r;
        int pos;
        r.status = ST_OK;
        if (act == ACT_INSERT)
        begin
            if (occupancy >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                // first entry with a strictly larger key, else the tail
                pos = occupancy;
                if (by_key)
                begin
                    for (int i = occupancy - 1; i >= 0; i--)
                        if (key < shadow_keys[i])
                            pos = i;
                end
                for (int i = occupancy; i > pos; i--)
                begin
                    shadow_keys[i]     = shadow_keys[i-1];
                    shadow_payloads[i] = shadow_payloads[i-1];
                end
                shadow_keys[pos]     = key;
                shadow_payloads[pos] = pay;
                occupancy++;
            end
        end
        else if (act == ACT_REMOVE)
        begin
            if (occupancy == 0)
                r.status = ST_EMPTY;
            else
            begin
                for (int i = 0; i + 1 < occupancy; i++)
                begin
                    shadow_keys[i]     = shadow_keys[i+1];
                    shadow_payloads[i] = shadow_payloads[i+1];
                end
                occupancy--;
            end
        end
        // inspect and the unused code leave the queue as it is
        r.key     = (occupancy > 0) ? shadow_keys[0] : '0;
        r.payload = (occupancy > 0) ? shadow_payloads[0] : '0;
        r.empty   = (occupancy == 0);
        r.full    = (occupancy >= DEPTH);
        r.count   = CNT_W'(occupancy);
        return r;
    endfunction

    // watch both channels and the config port at every rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy = 0;
            by_key    = 1'b1;
            expected_heads.delete();
            fail_count    = 0;
            waiting_count = 0;
        end
        else
        begin
            // result side first: it always belongs to an earlier item
            if (out_valid && out_ready)
            begin
                seen.key     = head_key;
                seen.payload = head_payload;
                seen.empty   = queue_empty;
                seen.full    = queue_full;
                seen.count   = entry_count;
                seen.status  = status;
                if (expected_heads.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t sipq_checker: result with nothing expected: key=%h payload=%h",
                                 $realtime, seen.key, seen.payload,
                                 " empty=%b full=%b count=%0d status=%0d",
                                 seen.empty, seen.full, seen.count, seen.status);
                end
                else
                begin
                    want = expected_heads.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t sipq_checker: mismatch: expected key=%h payload=%h",
                                     $realtime, want.key, want.payload,
                                     " empty=%b full=%b count=%0d status=%0d",
                                     want.empty, want.full, want.count, want.status,
                                     " / got key=%h payload=%h",
                                     seen.key, seen.payload,
                                     " empty=%b full=%b count=%0d status=%0d",
                                     seen.empty, seen.full, seen.count, seen.status);
                    end
                end
            end

            // accepted request
            if (in_valid && in_ready)
                expected_heads.push_back(apply_request(action, item_key, item_payload));

            // order mode write
            if (cfg_we)
                by_key = cfg_wdata;

            waiting_count = expected_heads.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the sorted insert priority queue: drives requests and
// result back-pressure, writes order_mode between phases and gives the verdict
// depends on sipq_pkg, sorted_insert_priority_queue and sipq_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sipq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int KEY_BITS    = 16;
    localparam int DATA_BITS   = 32;
    localparam int PERIOD      = 8;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 222;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AFTER  = 600;

    // the spare action code, reported like inspect
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_wdata;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  action;
    logic [KEY_BITS-1:0]         item_key;
    logic [DATA_BITS-1:0]        item_payload;
    logic                        out_valid;
    logic                        out_ready;
    logic [KEY_BITS-1:0]         head_key;
    logic [DATA_BITS-1:0]        head_payload;
    logic                        queue_empty;
    logic                        queue_full;
    logic [$clog2(DEPTH+1)-1:0]  entry_count;
    logic [1:0]                  status;

    int fail_count;
    int waiting_count;
    int sent_count;

    sorted_insert_priority_queue #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .item_key     (item_key),
        .item_payload (item_payload),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .head_key     (head_key),
        .head_payload (head_payload),
        .queue_empty  (queue_empty),
        .queue_full   (queue_full),
        .entry_count  (entry_count),
        .status       (status)
    );

    sipq_checker #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .item_key      (item_key),
        .item_payload  (item_payload),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .head_key      (head_key),
        .head_payload  (head_payload),
        .queue_empty   (queue_empty),
        .queue_full    (queue_full),
        .entry_count   (entry_count),
        .status        (status),
        .fail_count    (fail_count),
        .waiting_count (waiting_count)
    );

    // clock
    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    // idle length: mostly short, now and then long
    function automatic int long_tail_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // keys: small range for ties, the extremes, or anything
    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return KEY_BITS'($urandom_range(0, 7));
        if (r == 4)
            return $urandom_range(0, 1) ? {KEY_BITS{1'b1}} : '0;
        return KEY_BITS'($urandom());
    endfunction

    // offer one item after an optional idle gap, return once accepted
    task automatic send(input logic [1:0] act, input logic [KEY_BITS-1:0] key,
                        input logic [DATA_BITS-1:0] pay, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        action       <= act;
        item_key     <= key;
        item_payload <= pay;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting_count != 0)
            @(negedge clk);
    endtask

    // result side: random ready runs and stalls, plus one long hold-off
    initial
    begin
        int hold_left;
        int run_left;
        bit held_long;
        hold_left = 0;
        run_left  = 0;
        held_long = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_long && sent_count >= HOLD_AFTER)
            begin
                held_long = 1'b1;
                hold_left = HOLD_CYCLES;
                run_left  = 0;
            end
            if (hold_left == 0 && run_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    hold_left = long_tail_gap();
                else
                    run_left = $urandom_range(1, 40);
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                run_left--;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        bit filling;
        bit quiet;
        int seg_left;
        int r;
        logic [1:0] act;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_INSPECT;
        item_key     = '0;
        item_payload = '0;
        sent_count   = 0;
        filling      = 1'b0;
        seg_left     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty queue cases, extremes, equal keys, fill to full
        send(ACT_REMOVE, '0, '0, 0);
        send(ACT_INSPECT, '0, '0, 0);
        send(ACT_UNUSED, '0, '0, 0);
        send(ACT_INSERT, {KEY_BITS{1'b1}}, {DATA_BITS{1'b1}}, 0);
        send(ACT_INSERT, '0, '0, 0);
        send(ACT_INSERT, 16'h8000, 32'h1111_1111, 0);
        send(ACT_INSERT, 16'h8000, 32'h2222_2222, 0);
        repeat (DEPTH - 4)
            send(ACT_INSERT, pick_key(), $urandom(), 0);
        send(ACT_INSERT, 16'h0001, 32'hdead_beef, 0);
        send(ACT_UNUSED, '0, '0, 0);
        repeat (3)
            send(ACT_REMOVE, '0, '0, 0);

        // random phases, alternating order mode
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= (phase % 2 == 0) ? 1'b0 : 1'b1;
            @(negedge clk);
            cfg_we <= 1'b0;
            quiet = (phase == 2 || phase == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // alternate fill-heavy and drain-heavy stretches
                if (seg_left == 0)
                begin
                    filling  = !filling;
                    seg_left = $urandom_range(20, 50);
                end
                seg_left--;
                r = $urandom_range(0, 99);
                if (r < 65)
                    act = filling ? ACT_INSERT : ACT_REMOVE;
                else if (r < 85)
                    act = filling ? ACT_REMOVE : ACT_INSERT;
                else if (r < 95)
                    act = ACT_INSPECT;
                else
                    act = ACT_UNUSED;
                send(act, pick_key(), $urandom(),
                     (quiet || $urandom_range(0, 2) != 0) ? 0 : long_tail_gap());
            end
        end

        drain_results();
        repeat (24) @(negedge clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
